// ===== design/uvg_pkg.sv =====
// uvg_pkg: shared types and constants for the uuid v7 generator core
// word layouts for the request and result channels, field widths, fixed codes
// no dependencies
`default_nettype none

package uvg_pkg;

  localparam int unsigned TS_W    = 48;
  localparam int unsigned SEQ_W   = 12;
  localparam int unsigned RAND_W  = 62;
  localparam int unsigned DRIFT_W = 16;
  localparam int unsigned HALF_W  = 64;

  localparam logic [DRIFT_W-1:0] DRIFT_RESET = 16'd2000;
  localparam logic [TS_W-1:0]    TS_MAX      = {TS_W{1'b1}};
  localparam logic [3:0]         UUID_VERSION = 4'h7;
  localparam logic [1:0]         UUID_VARIANT = 2'b10;

  typedef struct packed {
    logic [TS_W-1:0]   now_ms;
    logic [SEQ_W-1:0]  fresh_seq;
    logic [RAND_W-1:0] random_bits;
  } in_word_t;

  typedef struct packed {
    logic              granted;
    logic [HALF_W-1:0] uuid_high;
    logic [HALF_W-1:0] uuid_low;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/uuid_v7_monotonic_generator_core.sv =====
// uuid_v7_monotonic_generator_core: monotonic version 7 uuid generator
// one request word in, one result word out; uses uvg_pkg
`default_nettype none

// Usage
//   in_valid/in_stall/in_word: one request per word (time in ms, sequence seed,
//   random tail). out_valid/out_stall/out_word: one result per request, with
//   granted low and a zero uuid when the drift limit refuses it.
//   cfg_we/cfg_wdata write max_drift_ms; write only while no request is in flight.
// Output register and throughput
//   The result is loaded into the output register at the accepting edge. One
//   request per cycle is sustained while out_stall is low: the timestamp and
//   sequence registers are updated at the accepting edge, so the next request
//   sees them in the following cycle. The path is 49-bit add/compare logic.
// Stall
//   While out_stall holds a waiting result, in_stall is raised; as soon as the
//   result is taken, or the output register is empty, a new request is taken in
//   the same cycle.
// Reset
//   Synchronous, active low: timestamp and sequence cleared, max_drift_ms back
//   to 2000, output register empty.
module uuid_v7_monotonic_generator_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire uvg_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output uvg_pkg::out_word_t     out_word,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata
);
  import uvg_pkg::*;

  logic [DRIFT_W-1:0] drift_r;
  logic [TS_W-1:0]    last_ts_r, last_ts_nxt;
  logic [SEQ_W-1:0]   last_seq_r, last_seq_nxt;
  logic               out_valid_r;
  out_word_t          out_word_r, out_word_nxt;

  logic               acc;
  logic [SEQ_W-1:0]   fresh;
  logic [TS_W:0]      ts_lead;
  logic [TS_W-1:0]    real_ts;
  logic [TS_W:0]      ts_limit;
  logic [TS_W:0]      ts_inc;
  logic [SEQ_W-1:0]   seq_pick;
  logic               ok;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    fresh    = (in_word.fresh_seq == '0) ? SEQ_W'(1) : in_word.fresh_seq;
    ts_lead  = {1'b0, last_ts_r} + {{(TS_W + 1 - DRIFT_W){1'b0}}, drift_r};
    // clamp the time to the allowed lead over the stored timestamp
    real_ts  = ({1'b0, in_word.now_ms} > ts_lead) ? ts_lead[TS_W-1:0] : in_word.now_ms;
    ts_limit = {1'b0, real_ts} + {{(TS_W + 1 - DRIFT_W){1'b0}}, drift_r};
    ts_inc   = {1'b0, last_ts_r} + {{TS_W{1'b0}}, 1'b1};
    seq_pick = ((last_seq_r == '0) && (real_ts == last_ts_r)) ? fresh
                                                              : last_seq_r + SEQ_W'(1);
    last_ts_nxt  = last_ts_r;
    last_seq_nxt = last_seq_r;
    if (real_ts > last_ts_r) begin
      ok           = 1'b1;
      last_ts_nxt  = real_ts;
      last_seq_nxt = fresh;
    end else if (seq_pick == '0) begin
      // sequence wrapped: borrow one ms of virtual time
      ok           = !(ts_inc > ts_limit) && (last_ts_r != TS_MAX);
      last_ts_nxt  = ts_inc[TS_W-1:0];
      last_seq_nxt = fresh;
    end else begin
      ok           = !({1'b0, last_ts_r} > ts_limit);
      last_seq_nxt = seq_pick;
    end

    out_word_nxt = '0;
    if (ok) begin
      out_word_nxt.granted   = 1'b1;
      out_word_nxt.uuid_high = {last_ts_nxt, UUID_VERSION, last_seq_nxt};
      out_word_nxt.uuid_low  = {UUID_VARIANT, in_word.random_bits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_r     <= DRIFT_RESET;
      last_ts_r   <= '0;
      last_seq_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        drift_r <= cfg_wdata;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
        if (ok) begin
          last_ts_r  <= last_ts_nxt;
          last_seq_r <= last_seq_nxt;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word only loads with an accepted request
  always_ff @(posedge clk) begin
    if (acc) begin
      out_word_r <= out_word_nxt;
    end
  end

  // a refused result carries an all-zero uuid
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.granted) |->
      (out_word_r.uuid_high == '0) && (out_word_r.uuid_low == '0))
    else $error("refused result carries nonzero uuid");

  // a granted uuid never has a zero sequence
  a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.granted) |-> (out_word_r.uuid_high[SEQ_W-1:0] != '0))
    else $error("granted uuid with zero sequence");

  // refusal leaves the stored state untouched
  a_refused_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !ok) |=> ($stable(last_ts_r) && $stable(last_seq_r)))
    else $error("refused request changed state");

  // granted requests strictly advance the combined timestamp and sequence value
  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ok) |=> ({last_ts_r, last_seq_r} > $past({last_ts_r, last_seq_r})))
    else $error("timestamp/sequence did not advance");

  // the output register empties when its result is taken and no new request is accepted
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !acc) |=> !out_valid_r)
    else $error("output valid without a request");

endmodule

`default_nettype wire
